// ===== src/mahd_pkg.sv =====
`timescale 1ns / 1ps
package mahd_pkg;

  // Raw header codes.
  localparam logic [1:0] VER_V25      = 2'd0;
  localparam logic [1:0] VER_RESERVED = 2'd1;
  localparam logic [1:0] VER_V2       = 2'd2;
  localparam logic [1:0] VER_V1       = 2'd3;

  localparam logic [1:0] LAYER_RESERVED = 2'd0;
  localparam logic [1:0] LAYER_III      = 2'd1;
  localparam logic [1:0] LAYER_II       = 2'd2;
  localparam logic [1:0] LAYER_I        = 2'd3;

  localparam logic [1:0] MODE_MONO = 2'd3;
  localparam logic [1:0] SIDX_RESERVED = 2'd3;
  localparam logic [10:0] SYNC_WORD = 11'h7ff;

  // Frame length is q = floor(m / D) with the divisor reduced per base rate.
  localparam int MW = 22;
  localparam int QW = 13;
  localparam int RW = 28;
  localparam int DW = 9;
  localparam logic [DW-1:0] DIV_44K = 9'd441;
  localparam logic [DW-1:0] DIV_48K = 9'd48;
  localparam logic [DW-1:0] DIV_32K = 9'd32;
  // floor(2^32 / D): the estimate is low by at most one.
  localparam logic [RW-1:0] RECIP_44K = 28'd9739154;
  localparam logic [RW-1:0] RECIP_48K = 28'd89478485;
  localparam logic [RW-1:0] RECIP_32K = 28'd134217728;

  // Bitrate table, columns: V1 L1, V1 L2, V1 L3, V2 L1, V2 L2/L3.
  localparam logic [8:0] BITRATE_TAB [16][5] = '{
    '{9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
    '{9'd32,  9'd32,  9'd32,  9'd32,  9'd8},
    '{9'd64,  9'd48,  9'd40,  9'd48,  9'd16},
    '{9'd96,  9'd56,  9'd48,  9'd56,  9'd24},
    '{9'd128, 9'd64,  9'd56,  9'd64,  9'd32},
    '{9'd160, 9'd80,  9'd64,  9'd80,  9'd40},
    '{9'd192, 9'd96,  9'd80,  9'd96,  9'd48},
    '{9'd224, 9'd112, 9'd96,  9'd112, 9'd56},
    '{9'd256, 9'd128, 9'd112, 9'd128, 9'd64},
    '{9'd288, 9'd160, 9'd128, 9'd144, 9'd80},
    '{9'd320, 9'd192, 9'd160, 9'd160, 9'd96},
    '{9'd352, 9'd224, 9'd192, 9'd176, 9'd112},
    '{9'd384, 9'd256, 9'd224, 9'd192, 9'd128},
    '{9'd416, 9'd320, 9'd256, 9'd224, 9'd144},
    '{9'd448, 9'd384, 9'd320, 9'd256, 9'd160},
    '{9'd0,   9'd0,   9'd0,   9'd0,   9'd0}
  };

  typedef struct packed {
    logic           ok;
    logic [1:0]     ver;
    logic [1:0]     lay;
    logic           prot;
    logic [1:0]     mode;
    logic [1:0]     nch;
    logic [8:0]     kbps;
    logic [15:0]    hz;
    logic [10:0]    spf;
    logic [5:0]     aot;
    logic [3:0]     fidx;
    logic           pad;
    logic           layer1;
    logic [MW-1:0]  m;
    logic [1:0]     sidx;
  } dec_t;

  function automatic logic [DW-1:0] div_of(input logic [1:0] sidx);
    logic [DW-1:0] d;
    case (sidx)
      2'd0:    d = DIV_44K;
      2'd1:    d = DIV_48K;
      default: d = DIV_32K;
    endcase
    return d;
  endfunction

  function automatic logic [RW-1:0] recip_of(input logic [1:0] sidx);
    logic [RW-1:0] r;
    case (sidx)
      2'd0:    r = RECIP_44K;
      2'd1:    r = RECIP_48K;
      default: r = RECIP_32K;
    endcase
    return r;
  endfunction

endpackage

// ===== src/mahd_decode.sv =====
`timescale 1ns / 1ps
module mahd_decode (
  input  logic [31:0]     header_word,
  input  logic [2:0]      bytes_available,
  output mahd_pkg::dec_t  dec
);
  import mahd_pkg::*;

  logic [10:0] sync;
  logic [1:0]  ver, lay, sidx, mode, vcol;
  logic [3:0]  bidx;
  logic [2:0]  col;
  logic        ok;
  logic [8:0]  kbps;
  logic [15:0] base_hz;
  logic [15:0] n_base;
  logic [17:0] n;
  logic [MW-1:0] m;
  logic [3:0]  fidx;

  assign sync = header_word[31:21];
  assign ver  = header_word[20:19];
  assign lay  = header_word[18:17];
  assign bidx = header_word[15:12];
  assign sidx = header_word[11:10];
  assign mode = header_word[7:6];

  assign ok = (bytes_available >= 3'd4) && (sync == SYNC_WORD) &&
              (ver != VER_RESERVED) && (lay != LAYER_RESERVED) &&
              (bidx != 4'd0) && (bidx != 4'd15) && (sidx != SIDX_RESERVED);

  always_comb begin
    if (ver == VER_V1) begin
      col = 3'd3 - {1'b0, lay};
    end else begin
      col = (lay == LAYER_I) ? 3'd3 : 3'd4;
    end
    case (ver)
      VER_V1:  vcol = 2'd0;
      VER_V2:  vcol = 2'd1;
      default: vcol = 2'd2;
    endcase
    case (sidx)
      2'd0:    base_hz = 16'd44100;
      2'd1:    base_hz = 16'd48000;
      default: base_hz = 16'd32000;
    endcase
    // ISO 14496-3 index; base rate 44.1k/48k/32k is 4/3/5, each halving adds 3.
    case (sidx)
      2'd0:    fidx = 4'd4 + 4'(3 * vcol);
      2'd1:    fidx = 4'd3 + 4'(3 * vcol);
      default: fidx = 4'd5 + 4'(3 * vcol);
    endcase
  end

  assign kbps = BITRATE_TAB[bidx][col];

  // 144 (or 12 for layer I) times kbps, scaled up as the rate halves and by ten at 44.1k.
  always_comb begin
    if (lay == LAYER_I) begin
      n_base = 16'(kbps * 12);
    end else begin
      n_base = 16'(kbps * 144);
    end
    n = {2'b00, n_base} << vcol;
    if (sidx == 2'd0) begin
      m = MW'(n * 10);
    end else begin
      m = MW'(n);
    end
  end

  always_comb begin
    dec = '0;
    if (ok) begin
      dec.ok     = 1'b1;
      dec.ver    = ver;
      dec.lay    = lay;
      dec.prot   = header_word[16];
      dec.mode   = mode;
      dec.nch    = (mode == MODE_MONO) ? 2'd1 : 2'd2;
      dec.kbps   = kbps;
      dec.hz     = base_hz >> vcol;
      dec.spf    = (lay == LAYER_I) ? 11'd384 : 11'd1152;
      dec.aot    = (lay == LAYER_I) ? 6'd32 : ((lay == LAYER_II) ? 6'd33 : 6'd34);
      dec.fidx   = fidx;
      dec.pad    = header_word[9];
      dec.layer1 = (lay == LAYER_I);
      dec.m      = m;
      dec.sidx   = sidx;
    end
  end

endmodule

// ===== src/mpeg_audio_header_decoder.sv =====
`timescale 1ns / 1ps
// MPEG-1/2/2.5 audio frame header decoder. Each input word carries the first
// four frame bytes (byte zero in bits 31..24) and the count of bytes present;
// each produces exactly one result word with the validity flag, the raw
// fields and the derived bitrate, sample rate, frame length, samples per
// frame, channel count, audio object type and ISO 14496-3 frequency index.
// A header that fails any check yields header_ok low and all other fields
// zero. The block is a three-stage pipeline: stage one decodes fields and
// looks up the tables, stage two multiplies by the reciprocal of the reduced
// sample-rate divisor, and stage three corrects the quotient and forms the
// frame length. It takes one word per cycle while out_ready is high; a word
// is registered in stages one, two and three in turn, and out_valid is the
// stage three flag. Stages hold their words under backpressure and empty
// stages fill up, so input is still taken while a result waits.
module mpeg_audio_header_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_header_word,
  input  logic [2:0]  in_bytes_available,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_header_ok,
  output logic [1:0]  out_version_code,
  output logic [1:0]  out_layer_code,
  output logic        out_protection_absent,
  output logic [1:0]  out_channel_mode,
  output logic [1:0]  out_num_channels,
  output logic [8:0]  out_bitrate_kbps,
  output logic [15:0] out_sample_rate_hz,
  output logic [11:0] out_frame_bytes,
  output logic [10:0] out_samples_per_frame,
  output logic [5:0]  out_audio_object_type,
  output logic [3:0]  out_freq_index
);
  import mahd_pkg::*;

  dec_t dec_nxt;
  dec_t s1_r, s2_r, s3_r;
  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_ready, s2_ready, s3_ready;

  logic [MW+RW-1:0] prod;
  logic [QW-1:0]    qest_nxt, s2_qest_r;
  logic [MW-1:0]    qd, rem;
  logic [QW-1:0]    q, qp;
  logic [11:0]      frame_nxt, frame_r;

  mahd_decode u_decode (
    .header_word     (in_header_word),
    .bytes_available (in_bytes_available),
    .dec             (dec_nxt)
  );

  // A stage can load when it is empty or its word moves on this cycle.
  assign s3_ready = !s3_v_r || out_ready;
  assign s2_ready = !s2_v_r || s3_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage two: quotient estimate from the reciprocal, low by at most one.
  assign prod     = s1_r.m * recip_of(s1_r.sidx);
  assign qest_nxt = prod[QW+31:32];

  // Stage three: one correction step, then padding and the layer I slot size.
  assign qd   = {{(MW-QW){1'b0}}, s2_qest_r} * {{(MW-DW){1'b0}}, div_of(s2_r.sidx)};
  assign rem  = s2_r.m - qd;
  assign q    = (rem >= MW'(div_of(s2_r.sidx))) ? s2_qest_r + 1'b1 : s2_qest_r;
  assign qp   = q + {{(QW-1){1'b0}}, s2_r.pad};
  assign frame_nxt = s2_r.layer1 ? {qp[9:0], 2'b00} : qp[11:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= in_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_ready) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_r <= dec_nxt;
    end
    if (s1_v_r && s2_ready) begin
      s2_r      <= s1_r;
      s2_qest_r <= qest_nxt;
    end
    if (s2_v_r && s3_ready) begin
      s3_r    <= s2_r;
      frame_r <= frame_nxt;
    end
  end

  assign out_valid             = s3_v_r;
  assign out_header_ok         = s3_r.ok;
  assign out_version_code      = s3_r.ver;
  assign out_layer_code        = s3_r.lay;
  assign out_protection_absent = s3_r.prot;
  assign out_channel_mode      = s3_r.mode;
  assign out_num_channels      = s3_r.nch;
  assign out_bitrate_kbps      = s3_r.kbps;
  assign out_sample_rate_hz    = s3_r.hz;
  assign out_frame_bytes       = frame_r;
  assign out_samples_per_frame = s3_r.spf;
  assign out_audio_object_type = s3_r.aot;
  assign out_freq_index        = s3_r.fidx;

endmodule

// ===== sim/mahd_tb_pkg.sv =====
`timescale 1ns / 1ps
package mahd_tb_pkg;

  // Bitrate index codes that never decode: "free" format and the forbidden value.
  localparam logic [3:0] BIDX_FREE = 4'd0;
  localparam logic [3:0] BIDX_BAD  = 4'd15;

  // A header is only complete with four bytes present.
  localparam logic [2:0] MIN_BYTES = 3'd4;

endpackage

// ===== sim/mahd_result_checker.sv =====
`timescale 1ns / 1ps
module mahd_result_checker
  import mahd_pkg::*;
  import mahd_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_header_word,
  input  logic [2:0]  in_bytes_available,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_header_ok,
  input  logic [1:0]  out_version_code,
  input  logic [1:0]  out_layer_code,
  input  logic        out_protection_absent,
  input  logic [1:0]  out_channel_mode,
  input  logic [1:0]  out_num_channels,
  input  logic [8:0]  out_bitrate_kbps,
  input  logic [15:0] out_sample_rate_hz,
  input  logic [11:0] out_frame_bytes,
  input  logic [10:0] out_samples_per_frame,
  input  logic [5:0]  out_audio_object_type,
  input  logic [3:0]  out_freq_index,
  output int          pending,
  output int          fail_count
);

  localparam logic [5:0] AOT_LAYER_I   = 6'd32;
  localparam logic [5:0] AOT_LAYER_II  = 6'd33;
  localparam logic [5:0] AOT_LAYER_III = 6'd34;
  localparam logic [3:0] FIDX_NONE     = 4'd13;

  // Columns: V1 layer I, V1 layer II, V1 layer III, V2/V2.5 layer I, V2/V2.5 layers II and III.
  localparam int unsigned KBPS_TAB [16][5] = '{
    '{0, 0, 0, 0, 0},          '{32, 32, 32, 32, 8},
    '{64, 48, 40, 48, 16},     '{96, 56, 48, 56, 24},
    '{128, 64, 56, 64, 32},    '{160, 80, 64, 80, 40},
    '{192, 96, 80, 96, 48},    '{224, 112, 96, 112, 56},
    '{256, 128, 112, 128, 64}, '{288, 160, 128, 144, 80},
    '{320, 192, 160, 160, 96}, '{352, 224, 192, 176, 112},
    '{384, 256, 224, 192, 128}, '{416, 320, 256, 224, 144},
    '{448, 384, 320, 256, 160}, '{0, 0, 0, 0, 0}
  };

  localparam int unsigned ISO_RATES [13] = '{
    96000, 88200, 64000, 48000, 44100, 32000, 24000,
    22050, 16000, 12000, 11025, 8000, 7350
  };

  typedef struct packed {
    logic        ok;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic        prot;
    logic [1:0]  mode;
    logic [1:0]  nch;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [11:0] fbytes;
    logic [10:0] spf;
    logic [5:0]  aot;
    logic [3:0]  fidx;
  } header_fields_t;

  header_fields_t expected_headers [$];
  int errors = 0;

  function automatic header_fields_t decode_header(input logic [31:0] w, input logic [2:0] n);
    header_fields_t   r;
    logic [1:0]       ver;
    logic [1:0]       lay;
    logic [1:0]       sidx;
    logic [1:0]       mode;
    logic [3:0]       bidx;
    logic             pad;
    int unsigned      col;
    int unsigned      kbps;
    int unsigned      hz;
    longint unsigned  bits_per_s;
    longint unsigned  len;
    r    = '0;
    ver  = w[20:19];
    lay  = w[18:17];
    bidx = w[15:12];
    sidx = w[11:10];
    pad  = w[9];
    mode = w[7:6];
    if (n < MIN_BYTES || w[31:21] != SYNC_WORD || ver == VER_RESERVED ||
        lay == LAYER_RESERVED || bidx == BIDX_FREE || bidx == BIDX_BAD ||
        sidx == SIDX_RESERVED) begin
      return r;
    end
    if (ver == VER_V1) begin
      col = (lay == LAYER_I) ? 0 : ((lay == LAYER_II) ? 1 : 2);
    end else begin
      col = (lay == LAYER_I) ? 3 : 4;
    end
    kbps = KBPS_TAB[bidx][col];
    case (sidx)
      2'd0:    hz = 44100;
      2'd1:    hz = 48000;
      default: hz = 32000;
    endcase
    // MPEG-2 halves the base rate and MPEG-2.5 quarters it.
    if (ver == VER_V2) begin
      hz = hz / 2;
    end else if (ver == VER_V25) begin
      hz = hz / 4;
    end
    bits_per_s = longint'(kbps) * 1000;
    if (lay == LAYER_I) begin
      len = ((12 * bits_per_s) / hz + pad) * 4;
    end else begin
      len = (144 * bits_per_s) / hz + pad;
    end
    r.ok     = 1'b1;
    r.ver    = ver;
    r.lay    = lay;
    r.prot   = w[16];
    r.mode   = mode;
    r.nch    = (mode == MODE_MONO) ? 2'd1 : 2'd2;
    r.kbps   = 9'(kbps);
    r.hz     = 16'(hz);
    r.fbytes = 12'(len);
    r.spf    = (lay == LAYER_I) ? 11'd384 : 11'd1152;
    r.aot    = (lay == LAYER_I) ? AOT_LAYER_I :
               ((lay == LAYER_II) ? AOT_LAYER_II : AOT_LAYER_III);
    r.fidx   = FIDX_NONE;
    for (int i = 12; i >= 0; i--) begin
      if (ISO_RATES[i] == hz) begin
        r.fidx = 4'(i);
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    header_fields_t want;
    header_fields_t got;
    if (rst_n) begin
      // Results leave before new headers are booked, so a result can never be
      // matched against the header taken at the same edge.
      if (out_valid && out_ready) begin
        got.ok     = out_header_ok;
        got.ver    = out_version_code;
        got.lay    = out_layer_code;
        got.prot   = out_protection_absent;
        got.mode   = out_channel_mode;
        got.nch    = out_num_channels;
        got.kbps   = out_bitrate_kbps;
        got.hz     = out_sample_rate_hz;
        got.fbytes = out_frame_bytes;
        got.spf    = out_samples_per_frame;
        got.aot    = out_audio_object_type;
        got.fidx   = out_freq_index;
        if (expected_headers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        end else begin
          want = expected_headers.pop_front();
          check_field("header_ok", want.ok, got.ok);
          check_field("version_code", want.ver, got.ver);
          check_field("layer_code", want.lay, got.lay);
          check_field("protection_absent", want.prot, got.prot);
          check_field("channel_mode", want.mode, got.mode);
          check_field("num_channels", want.nch, got.nch);
          check_field("bitrate_kbps", want.kbps, got.kbps);
          check_field("sample_rate_hz", want.hz, got.hz);
          check_field("frame_bytes", want.fbytes, got.fbytes);
          check_field("samples_per_frame", want.spf, got.spf);
          check_field("audio_object_type", want.aot, got.aot);
          check_field("freq_index", want.fidx, got.fidx);
        end
      end
      if (in_valid && in_ready) begin
        expected_headers.push_back(decode_header(in_header_word, in_bytes_available));
      end
    end
    pending    <= expected_headers.size();
    fail_count <= errors;
  end

endmodule

// ===== sim/tb_mpeg_audio_header_decoder.sv =====
`timescale 1ns / 1ps
module tb_mpeg_audio_header_decoder;
  import mahd_pkg::*;
  import mahd_tb_pkg::*;

  // The watchdog bound lies far above the slowest legal run and only catches a
  // hung handshake.
  localparam int LIMIT_CYCLES    = 400000;
  // Long receiver hold-off, far longer than the three-stage pipeline.
  localparam int HOLD_CYCLES     = 300;
  // Extra cycles waited after the last result.
  localparam int TAIL_CYCLES     = 12;
  localparam int WORDS_PER_PHASE = 400;
  // Idling phases: none, sender only, receiver only, both lightly.
  localparam int IDLE_PCT  [4] = '{0, 55, 0, 9};
  localparam int STALL_PCT [4] = '{0, 0, 55, 9};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_header_word = '0;
  logic [2:0]  in_bytes_available = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_header_ok;
  logic [1:0]  out_version_code;
  logic [1:0]  out_layer_code;
  logic        out_protection_absent;
  logic [1:0]  out_channel_mode;
  logic [1:0]  out_num_channels;
  logic [8:0]  out_bitrate_kbps;
  logic [15:0] out_sample_rate_hz;
  logic [11:0] out_frame_bytes;
  logic [10:0] out_samples_per_frame;
  logic [5:0]  out_audio_object_type;
  logic [3:0]  out_freq_index;

  int   pending;
  int   fail_count;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycles = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mpeg_audio_header_decoder dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_header_word        (in_header_word),
    .in_bytes_available    (in_bytes_available),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_header_ok         (out_header_ok),
    .out_version_code      (out_version_code),
    .out_layer_code        (out_layer_code),
    .out_protection_absent (out_protection_absent),
    .out_channel_mode      (out_channel_mode),
    .out_num_channels      (out_num_channels),
    .out_bitrate_kbps      (out_bitrate_kbps),
    .out_sample_rate_hz    (out_sample_rate_hz),
    .out_frame_bytes       (out_frame_bytes),
    .out_samples_per_frame (out_samples_per_frame),
    .out_audio_object_type (out_audio_object_type),
    .out_freq_index        (out_freq_index)
  );

  // The checker sees both channels exactly as the block does and keeps its
  // own decode of every accepted header word.
  mahd_result_checker chk (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_header_word        (in_header_word),
    .in_bytes_available    (in_bytes_available),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_header_ok         (out_header_ok),
    .out_version_code      (out_version_code),
    .out_layer_code        (out_layer_code),
    .out_protection_absent (out_protection_absent),
    .out_channel_mode      (out_channel_mode),
    .out_num_channels      (out_num_channels),
    .out_bitrate_kbps      (out_bitrate_kbps),
    .out_sample_rate_hz    (out_sample_rate_hz),
    .out_frame_bytes       (out_frame_bytes),
    .out_samples_per_frame (out_samples_per_frame),
    .out_audio_object_type (out_audio_object_type),
    .out_freq_index        (out_freq_index),
    .pending               (pending),
    .fail_count            (fail_count)
  );

  // Builds a header with a correct sync. Protection, private and the trailing
  // six bits are taken from the noise word so they vary without extra arguments.
  function automatic logic [31:0] pack_header(input logic [1:0] ver, input logic [1:0] lay,
                                              input logic [3:0] bidx, input logic [1:0] sidx,
                                              input logic pad, input logic [1:0] mode,
                                              input logic [31:0] noise);
    return {SYNC_WORD, ver, lay, noise[16], bidx, sidx, pad, noise[8], mode, noise[5:0]};
  endfunction

  // Most words are well-formed headers with random content, since those are
  // the only ones that reach the bitrate and frame length arithmetic. About
  // one in seven breaks exactly one validity rule, and the rest is noise.
  task automatic random_header(output logic [31:0] w, output logic [2:0] n);
    int unsigned pick;
    logic [1:0]  ver;
    pick = $urandom_range(99);
    case ($urandom_range(2))
      0:       ver = VER_V25;
      1:       ver = VER_V2;
      default: ver = VER_V1;
    endcase
    w = pack_header(ver, 2'($urandom_range(LAYER_I, LAYER_III)),
                    4'($urandom_range(BIDX_BAD - 1, BIDX_FREE + 1)),
                    2'($urandom_range(SIDX_RESERVED - 1)), 1'($urandom_range(1)),
                    2'($urandom_range(3)), $urandom);
    n = 3'($urandom_range(7, MIN_BYTES));
    if (pick >= 90) begin
      w = $urandom;
      n = 3'($urandom_range(7));
    end else if (pick >= 75) begin
      case ($urandom_range(6))
        0:       w[21 + $urandom_range(10)] = 1'b0;
        1:       w[20:19] = VER_RESERVED;
        2:       w[18:17] = LAYER_RESERVED;
        3:       w[15:12] = BIDX_FREE;
        4:       w[15:12] = BIDX_BAD;
        5:       w[11:10] = SIDX_RESERVED;
        default: n = 3'($urandom_range(MIN_BYTES - 1));
      endcase
    end
  endtask

  // Offers one header word, with random idle cycles in front of it, and
  // returns at the edge where it is taken. Valid stays high afterwards so that
  // back-to-back words need no extra assignment.
  task automatic send_header(input logic [31:0] w, input logic [2:0] n);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_header_word     <= w;
    in_bytes_available <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The sender goes quiet until the checker has seen every result it is owed.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls at the rate of the current phase, and on
  // request one long hold-off, counted here, during which the pipeline fills
  // and the block has to push back on its input.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] base;
    logic [31:0] w;
    logic [2:0]  n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words. The base is a plain MPEG-1 layer III header at 128 kbps.
    base = pack_header(VER_V1, LAYER_III, 4'd9, 2'd0, 1'b0, 2'd0, 32'h0);
    send_header(32'h0000_0000, 3'd0);
    send_header(32'hffff_ffff, 3'd7);
    send_header(base, MIN_BYTES);
    // Layer I at its top bitrate and lowest MPEG-1 rate, padded.
    send_header(pack_header(VER_V1, LAYER_I, 4'd14, 2'd2, 1'b1, MODE_MONO, 32'h0), MIN_BYTES);
    send_header(pack_header(VER_V1, LAYER_II, 4'd1, 2'd1, 1'b0, 2'd1, 32'h0), 3'd5);
    send_header(pack_header(VER_V2, LAYER_I, 4'd14, 2'd1, 1'b1, 2'd2, 32'h0), 3'd6);
    send_header(pack_header(VER_V2, LAYER_III, 4'd1, 2'd0, 1'b0, MODE_MONO, 32'h0), 3'd7);
    // The longest frame there is: MPEG-2.5 layer II at 160 kbps and 8 kHz, padded.
    send_header(pack_header(VER_V25, LAYER_II, 4'd14, 2'd2, 1'b1, 2'd0, 32'h0), MIN_BYTES);
    send_header(pack_header(VER_V25, LAYER_I, 4'd7, 2'd0, 1'b1, 2'd3, 32'h0), MIN_BYTES);
    // Protection, private and trailing bits all set on an otherwise plain header.
    send_header(pack_header(VER_V1, LAYER_III, 4'd9, 2'd0, 1'b0, 2'd0, 32'hffff_ffff),
                MIN_BYTES);
    // Each validity rule broken on its own.
    send_header(base & ~32'h0020_0000, MIN_BYTES);
    send_header(base & ~32'h8000_0000, MIN_BYTES);
    send_header({base[31:21], VER_RESERVED, base[18:0]}, MIN_BYTES);
    send_header({base[31:19], LAYER_RESERVED, base[16:0]}, MIN_BYTES);
    send_header({base[31:16], BIDX_FREE, base[11:0]}, MIN_BYTES);
    send_header({base[31:16], BIDX_BAD, base[11:0]}, MIN_BYTES);
    send_header({base[31:12], SIDX_RESERVED, base[9:0]}, MIN_BYTES);
    send_header(base, MIN_BYTES - 3'd1);
    send_header(base, 3'd0);
    drain_results();

    // Random words in four idling phases. The first phase runs without any
    // idling and carries the long receiver hold-off part way through; each
    // phase ends with the sender waiting for every result.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = IDLE_PCT[phase];
      stall_pct = STALL_PCT[phase];
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (phase == 0 && k == 100) begin
          hold_req = 1'b1;
        end
        random_header(w, n);
        send_header(w, n);
      end
      drain_results();
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
